[rtl/cfft_pkg.sv]
// ----------------------------------------------------------------------------
// cfft_pkg
// Shared types and constants for the connection credit and frame tracker:
// event codes, register indexes, frame status and the channel payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package cfft_pkg;

   // field widths
   localparam int LIMIT_W = 62;
   localparam int OP_W    = 4;
   localparam int CSR_IDX_W = 1;

   // event codes
   localparam logic [OP_W-1:0] OP_QUERY         = 4'd0;
   localparam logic [OP_W-1:0] OP_PEER_LIMIT    = 4'd1;
   localparam logic [OP_W-1:0] OP_QUEUE_MAXDATA = 4'd2;
   localparam logic [OP_W-1:0] OP_TAKE_MAXDATA  = 4'd3;
   localparam logic [OP_W-1:0] OP_ACK_MAXDATA   = 4'd4;
   localparam logic [OP_W-1:0] OP_LOST_MAXDATA  = 4'd5;
   localparam logic [OP_W-1:0] OP_QUEUE_BLOCKED = 4'd6;
   localparam logic [OP_W-1:0] OP_TAKE_BLOCKED  = 4'd7;
   localparam logic [OP_W-1:0] OP_ACK_BLOCKED   = 4'd8;
   localparam logic [OP_W-1:0] OP_LOST_BLOCKED  = 4'd9;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INIT_PEER_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_ADV_LIMIT  = 1'b1;

   // frame kinds
   localparam logic FRAME_MAXDATA = 1'b0;
   localparam logic FRAME_BLOCKED = 1'b1;

   // life cycle of one control frame
   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_PENDING = 2'd1,
      ST_SENT    = 2'd2,
      ST_ACKED   = 2'd3
   } frame_status_type;

   // one event on the request channel
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [LIMIT_W-1:0] limit_value;
      logic [LIMIT_W-1:0] queued_total;
      logic [LIMIT_W-1:0] sent_offset;
   } req_type;

   // one result on the response channel
   typedef struct packed {
      logic [LIMIT_W-1:0] send_allowance;
      logic               blocked_due;
      logic               frame_valid;
      logic               frame_kind;
      logic [LIMIT_W-1:0] frame_limit;
   } rsp_type;

   // post-event values handed to the credit stage
   typedef struct packed {
      logic [LIMIT_W-1:0] peer_limit;
      logic [LIMIT_W-1:0] queued_total;
      logic [LIMIT_W-1:0] sent_offset;
      logic               frame_valid;
      logic               frame_kind;
      logic [LIMIT_W-1:0] frame_limit;
   } mid_type;

   // controls for one frame tracker, at most one set per event
   typedef struct packed {
      logic store;
      logic take;
      logic ack;
      logic lost;
   } frame_ctrl_type;

endpackage

`default_nettype wire

[rtl/cfft_frame.sv]
// ----------------------------------------------------------------------------
// cfft_frame
// Tracks one control frame: its value, whether present, and its status
// through none, pending, sent and acknowledged.
// ----------------------------------------------------------------------------
`default_nettype none

module cfft_frame (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cfft_pkg::frame_ctrl_type    ctrl,
   input  wire logic [cfft_pkg::LIMIT_W-1:0] store_value,
   output logic [cfft_pkg::LIMIT_W-1:0]     frame_value,
   output logic                             frame_present,
   output cfft_pkg::frame_status_type       frame_status,
   output logic                             emit
);
   import cfft_pkg::*;

   logic [LIMIT_W-1:0] value_ff, value_in;
   logic               present_ff, present_in;
   frame_status_type   status_ff, status_in;
   logic               match;

   assign match = present_ff && (value_ff == store_value);

   // next status
   always_comb begin
      value_in   = value_ff;
      present_in = present_ff;
      status_in  = status_ff;
      priority if (ctrl.store) begin
         value_in   = store_value;
         present_in = 1'b1;
         status_in  = ST_PENDING;
      end else if (ctrl.take && present_ff && status_ff == ST_PENDING) begin
         status_in = ST_SENT;
      end else if (ctrl.ack && match) begin
         status_in = ST_ACKED;
      end else if (ctrl.lost && match && status_ff != ST_ACKED) begin
         status_in = ST_PENDING;
      end else begin
         status_in = status_ff;
      end
   end

   // outputs
   always_comb begin
      frame_value   = value_ff;
      frame_present = present_ff;
      frame_status  = status_ff;
      emit          = ctrl.take && present_ff && (status_ff == ST_PENDING);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         status_ff  <= ST_NONE;
      end else begin
         present_ff <= present_in;
         status_ff  <= status_in;
      end
   end

   // value is qualified by present, no reset needed
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

[rtl/cfft_event_unit.sv]
// ----------------------------------------------------------------------------
// cfft_event_unit
// Applies one event to the limit and frame state and hands the post-event
// peer limit and any emitted frame on to the credit stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cfft_event_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire cfft_pkg::req_type             ev,
   input  wire logic                          csr_we,
   input  wire logic [cfft_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cfft_pkg::LIMIT_W-1:0]  csr_wdata,
   output cfft_pkg::mid_type                  mid
);
   import cfft_pkg::*;

   logic [LIMIT_W-1:0] peer_limit_ff, peer_limit_in;
   logic [LIMIT_W-1:0] adv_limit_ff, adv_limit_in;
   frame_ctrl_type     md_ctrl, bl_ctrl;
   logic [LIMIT_W-1:0] md_value, bl_value;
   logic               md_present, bl_present;
   frame_status_type   md_status, bl_status;
   logic               md_emit, bl_emit;
   logic               adv_raise, bl_dup;

   assign adv_raise = ev.limit_value > adv_limit_ff;
   assign bl_dup    = bl_present && (bl_value == ev.limit_value) &&
                      (bl_status != ST_NONE);

   // event decode
   always_comb begin
      md_ctrl = '0;
      bl_ctrl = '0;
      if (go) begin
         unique case (ev.op)
            OP_QUEUE_MAXDATA: md_ctrl.store = adv_raise;
            OP_TAKE_MAXDATA:  md_ctrl.take  = 1'b1;
            OP_ACK_MAXDATA:   md_ctrl.ack   = 1'b1;
            OP_LOST_MAXDATA:  md_ctrl.lost  = 1'b1;
            OP_QUEUE_BLOCKED: bl_ctrl.store = !bl_dup;
            OP_TAKE_BLOCKED:  bl_ctrl.take  = 1'b1;
            OP_ACK_BLOCKED:   bl_ctrl.ack   = 1'b1;
            OP_LOST_BLOCKED:  bl_ctrl.lost  = 1'b1;
            default: begin
               md_ctrl = '0;
               bl_ctrl = '0;
            end
         endcase
      end
   end

   // limits only rise; a register write loads the limit directly
   always_comb begin
      peer_limit_in = peer_limit_ff;
      adv_limit_in  = adv_limit_ff;
      if (csr_we) begin
         if (csr_index == REG_INIT_PEER_LIMIT) begin
            peer_limit_in = csr_wdata;
         end
         if (csr_index == REG_INIT_ADV_LIMIT) begin
            adv_limit_in = csr_wdata;
         end
      end else if (go) begin
         if (ev.op == OP_PEER_LIMIT && ev.limit_value > peer_limit_ff) begin
            peer_limit_in = ev.limit_value;
         end
         if (md_ctrl.store) begin
            adv_limit_in = ev.limit_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_limit_ff <= '0;
         adv_limit_ff  <= '0;
      end else begin
         peer_limit_ff <= peer_limit_in;
         adv_limit_ff  <= adv_limit_in;
      end
   end

   cfft_frame u_maxdata (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (md_ctrl),
      .store_value   (ev.limit_value),
      .frame_value   (md_value),
      .frame_present (md_present),
      .frame_status  (md_status),
      .emit          (md_emit)
   );

   cfft_frame u_blocked (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (bl_ctrl),
      .store_value   (ev.limit_value),
      .frame_value   (bl_value),
      .frame_present (bl_present),
      .frame_status  (bl_status),
      .emit          (bl_emit)
   );

   // post-event values; a raised peer limit counts at once
   always_comb begin
      mid.peer_limit   = peer_limit_in;
      mid.queued_total = ev.queued_total;
      mid.sent_offset  = ev.sent_offset;
      mid.frame_valid  = md_emit || bl_emit;
      mid.frame_kind   = bl_emit ? FRAME_BLOCKED : FRAME_MAXDATA;
      if (md_emit) begin
         mid.frame_limit = md_value;
      end else if (bl_emit) begin
         mid.frame_limit = bl_value;
      end else begin
         mid.frame_limit = '0;
      end
      if (md_status == ST_NONE && md_present) begin
         mid.frame_kind = mid.frame_kind;
      end
   end

endmodule

`default_nettype wire

[rtl/cfft_credit_calc.sv]
// ----------------------------------------------------------------------------
// cfft_credit_calc
// Works out sendable bytes and the blocked flag from the post-event
// peer limit, queued bytes and sent offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cfft_credit_calc (
   input  wire cfft_pkg::mid_type mid,
   output cfft_pkg::rsp_type      rsp
);
   import cfft_pkg::*;

   logic [LIMIT_W-1:0] credit, unsent;

   // both differences floored at zero
   always_comb begin
      credit = (mid.peer_limit > mid.sent_offset) ?
               mid.peer_limit - mid.sent_offset : '0;
      unsent = (mid.queued_total > mid.sent_offset) ?
               mid.queued_total - mid.sent_offset : '0;
   end

   always_comb begin
      rsp.send_allowance = (credit < unsent) ? credit : unsent;
      rsp.blocked_due    = mid.queued_total > mid.peer_limit;
      rsp.frame_valid    = mid.frame_valid;
      rsp.frame_kind     = mid.frame_kind;
      rsp.frame_limit    = mid.frame_limit;
   end

endmodule

`default_nettype wire

[rtl/connection_credit_and_frame_tracker_unit.sv]
// ----------------------------------------------------------------------------
// connection_credit_and_frame_tracker_unit
// Connection-level credit tracker with max-data and data-blocked control
// frame life cycles. One event in, one result out.
//
// Usage:
//  - req_*: one event per transfer (op, limit, queued bytes, sent offset).
//  - rsp_*: one result per event, in order: sendable bytes, blocked flag
//    and any control frame emitted by a take event.
//  - csr_*: write-only; index 0 loads the peer limit, index 1 the
//    advertised limit. Write only while no event is in flight.
//  - Three register stages: input, event (state update), result. Response
//    valid is the valid flag of the result register; one event per
//    cycle is sustained while rsp_ready stays high.
//  - Reset clears both limits to zero and returns both frames to none.
//  - When rsp_ready is low the stages fill up; req_ready drops only once
//    all three hold an event, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_credit_and_frame_tracker_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire cfft_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output cfft_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [cfft_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cfft_pkg::LIMIT_W-1:0]  csr_wdata
);
   import cfft_pkg::*;

   logic    in_valid_ff, in_valid_in;
   logic    mid_valid_ff, mid_valid_in;
   logic    out_valid_ff, out_valid_in;
   req_type in_ff;
   mid_type mid_ff, mid_comb;
   rsp_type out_ff, out_comb;
   logic    out_load_ok, mid_free, mid_go, in_free, in_go;

   // stage advance, ready chained back from the response side
   always_comb begin
      out_load_ok  = !out_valid_ff || rsp_ready;
      mid_go       = mid_valid_ff && out_load_ok;
      mid_free     = !mid_valid_ff || out_load_ok;
      in_go        = in_valid_ff && mid_free;
      in_free      = !in_valid_ff || mid_free;
      in_valid_in  = in_free ? req_valid : in_valid_ff;
      mid_valid_in = mid_free ? in_go : mid_valid_ff;
      out_valid_in = out_load_ok ? mid_go : out_valid_ff;
   end

   assign req_ready = in_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && in_free) begin
         in_ff <= req_data;
      end
      if (in_go) begin
         mid_ff <= mid_comb;
      end
      if (mid_go) begin
         out_ff <= out_comb;
      end
   end

   cfft_event_unit u_event (
      .clock     (clock),
      .reset     (reset),
      .go        (in_go),
      .ev        (in_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mid       (mid_comb)
   );

   cfft_credit_calc u_credit (
      .mid (mid_ff),
      .rsp (out_comb)
   );

endmodule

`default_nettype wire

[test/credit_frame_checker.sv]
// ----------------------------------------------------------------------------
// credit_frame_checker
// Watches the request, response and register ports of the credit and frame
// tracker. It keeps its own copy of the limits and of both control frames,
// works out the result of every request transfer and compares each response
// transfer with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module credit_frame_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  cfft_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  cfft_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [cfft_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cfft_pkg::LIMIT_W-1:0]   csr_wdata,
   output int                             mismatch_count,
   output int                             results_waiting,
   output int                             results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import cfft_pkg::*;

   // one control frame as the tracker sees it
   typedef struct packed {
      logic [LIMIT_W-1:0] value;
      logic               present;
      frame_status_type   status;
   } frame_track_type;

   logic [LIMIT_W-1:0] peer_lim;
   logic [LIMIT_W-1:0] adv_lim;
   frame_track_type    frames [2];
   rsp_type            expected_results [$];

   // store a new frame value and make it ready to go out
   function automatic void mark_pending(input logic kind, input logic [LIMIT_W-1:0] val);
      frames[kind].value   = val;
      frames[kind].present = 1'b1;
      frames[kind].status  = ST_PENDING;
   endfunction

   // apply one event to the local state and return the response it gives
   function automatic rsp_type credit_after_event(input req_type ev);
      rsp_type            res;
      logic               kind;
      logic [LIMIT_W-1:0] credit;
      logic [LIMIT_W-1:0] unsent;
      res  = '0;
      kind = (ev.op >= OP_QUEUE_BLOCKED) ? FRAME_BLOCKED : FRAME_MAXDATA;
      case (ev.op)
         OP_PEER_LIMIT: begin
            if (ev.limit_value > peer_lim) peer_lim = ev.limit_value;
         end
         OP_QUEUE_MAXDATA: begin
            if (ev.limit_value > adv_lim) begin
               adv_lim = ev.limit_value;
               mark_pending(FRAME_MAXDATA, ev.limit_value);
            end
         end
         OP_QUEUE_BLOCKED: begin
            // same value already in flight: nothing new to send
            if (!(frames[FRAME_BLOCKED].present &&
                  frames[FRAME_BLOCKED].value == ev.limit_value &&
                  frames[FRAME_BLOCKED].status != ST_NONE))
               mark_pending(FRAME_BLOCKED, ev.limit_value);
         end
         OP_TAKE_MAXDATA, OP_TAKE_BLOCKED: begin
            if (frames[kind].present && frames[kind].status == ST_PENDING) begin
               frames[kind].status = ST_SENT;
               res.frame_valid     = 1'b1;
               res.frame_kind      = kind;
               res.frame_limit     = frames[kind].value;
            end
         end
         OP_ACK_MAXDATA, OP_ACK_BLOCKED: begin
            if (frames[kind].present && frames[kind].value == ev.limit_value)
               frames[kind].status = ST_ACKED;
         end
         OP_LOST_MAXDATA, OP_LOST_BLOCKED: begin
            if (frames[kind].status != ST_ACKED && frames[kind].present &&
                frames[kind].value == ev.limit_value)
               frames[kind].status = ST_PENDING;
         end
         default: ;
      endcase

      // credit figures use the limits as updated by this event
      credit = (peer_lim > ev.sent_offset) ? peer_lim - ev.sent_offset : '0;
      unsent = (ev.queued_total > ev.sent_offset) ?
               ev.queued_total - ev.sent_offset : '0;
      res.send_allowance = (credit < unsent) ? credit : unsent;
      res.blocked_due    = (ev.queued_total > peer_lim);
      return res;
   endfunction

   // sample every port at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         peer_lim = '0;
         adv_lim  = '0;
         frames[FRAME_MAXDATA] = '0;
         frames[FRAME_BLOCKED] = '0;
         expected_results.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         // response transfer against the oldest outstanding result
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t: response with nothing outstanding: sendable=%0d",
                           $realtime, rsp_data.send_allowance);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_data.send_allowance !== want.send_allowance ||
                   rsp_data.blocked_due    !== want.blocked_due ||
                   rsp_data.frame_valid    !== want.frame_valid ||
                   rsp_data.frame_kind     !== want.frame_kind ||
                   rsp_data.frame_limit    !== want.frame_limit) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%t: result %0d differs", $realtime, results_checked);
                     $display("   expected sendable=%0d blocked=%b frame=%b kind=%b limit=%0d",
                              want.send_allowance, want.blocked_due, want.frame_valid,
                              want.frame_kind, want.frame_limit);
                     $display("   actual   sendable=%0d blocked=%b frame=%b kind=%b limit=%0d",
                              rsp_data.send_allowance, rsp_data.blocked_due,
                              rsp_data.frame_valid, rsp_data.frame_kind,
                              rsp_data.frame_limit);
                  end
               end
            end
         end

         // register writes load the working limits directly
         if (csr_we) begin
            case (csr_index)
               REG_INIT_PEER_LIMIT: peer_lim = csr_wdata;
               REG_INIT_ADV_LIMIT:  adv_lim  = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            want = credit_after_event(req_data);
            expected_results = {expected_results, want};
         end
      end
      results_waiting = expected_results.size();
   end

endmodule

[test/connection_credit_and_frame_tracker_unit_test.sv]
// ----------------------------------------------------------------------------
// connection_credit_and_frame_tracker_unit_test
// Drives events into the credit and frame tracker with random gaps on both
// channels: a directed set of corner cases first, then frame life cycles and
// loose events under several limit settings. The checker beside the block
// reports the failures; this module gives the verdict.
// ----------------------------------------------------------------------------
module connection_credit_and_frame_tracker_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cfft_pkg::*;

   localparam logic [LIMIT_W-1:0] LIM_MAX = '1;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd10;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;
   localparam int EVENTS_PER_PHASE = 125;
   localparam int PHASES = 5;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]   csr_wdata;

   int mismatch_count;
   int results_waiting;
   int results_checked;

   // stimulus hints, so that acks, losses and raises hit live values
   logic [LIMIT_W-1:0] peer_hint;
   logic [LIMIT_W-1:0] adv_hint;
   logic [LIMIT_W-1:0] md_value;
   logic [LIMIT_W-1:0] bk_value;
   int                 events_sent;
   int                 settings_used;
   bit                 calm_sender;

   connection_credit_and_frame_tracker_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   credit_frame_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_waiting (results_waiting),
      .results_checked (results_checked)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop
   initial begin
      #2ms;
      $display("timeout with %0d results outstanding", results_waiting);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // idle lengths: mostly none, some short, a few long
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [LIMIT_W-1:0] rand62();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[LIMIT_W-1:0];
   endfunction

   // a value near the given one, or one of the extremes
   function automatic logic [LIMIT_W-1:0] near_value(input logic [LIMIT_W-1:0] base);
      logic [LIMIT_W-1:0] d;
      d = LIMIT_W'($urandom_range(1, 64));
      case ($urandom_range(0, 6))
         0: return base;
         1: return (base > d) ? base - d : '0;
         2: return (base > LIM_MAX - d) ? LIM_MAX : base + d;
         3: return LIM_MAX - LIMIT_W'($urandom_range(0, 2));
         4: return LIMIT_W'($urandom_range(0, 4000));
         default: return rand62();
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] raise_value(input logic [LIMIT_W-1:0] base);
      return (base >= LIM_MAX - 1000) ? LIM_MAX : base + LIMIT_W'($urandom_range(1, 1000));
   endfunction

   // one request transfer; called and returns at a falling edge
   task automatic push_event(input logic [OP_W-1:0] op, input logic [LIMIT_W-1:0] lim,
                             input logic [LIMIT_W-1:0] queued,
                             input logic [LIMIT_W-1:0] sent);
      int g;
      g = calm_sender ? 0 : gap_cycles();
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_data.op           = op;
      req_data.limit_value  = lim;
      req_data.queued_total = queued;
      req_data.sent_offset  = sent;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);

      if (op == OP_PEER_LIMIT && lim > peer_hint) peer_hint = lim;
      if (op == OP_QUEUE_MAXDATA && lim > adv_hint) begin
         adv_hint = lim;
         md_value = lim;
      end
      if (op == OP_QUEUE_BLOCKED) bk_value = lim;
      if (op <= OP_LOST_BLOCKED) events_sent++;
   endtask

   // byte counts clustered around the peer limit
   task automatic push_with_bytes(input logic [OP_W-1:0] op, input logic [LIMIT_W-1:0] lim);
      logic [LIMIT_W-1:0] queued;
      queued = near_value(peer_hint);
      push_event(op, lim, queued, near_value($urandom_range(0, 1) ? queued : peer_hint));
   endtask

   // wait for the block to drain, then load both limits
   task automatic load_limits(input logic [LIMIT_W-1:0] peer, input logic [LIMIT_W-1:0] adv);
      req_valid = 1'b0;
      while (results_waiting != 0) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = REG_INIT_PEER_LIMIT;
      csr_wdata = peer;
      @(negedge clock);
      csr_index = REG_INIT_ADV_LIMIT;
      csr_wdata = adv;
      @(negedge clock);
      csr_we    = 1'b0;
      peer_hint = peer;
      adv_hint  = adv;
      settings_used++;
   endtask

   // queue, take, possibly lose and resend, then usually ack
   task automatic frame_episode(input logic kind);
      logic [LIMIT_W-1:0] lim;
      lim = kind ? near_value(peer_hint) : raise_value(adv_hint);
      push_with_bytes(kind ? OP_QUEUE_BLOCKED : OP_QUEUE_MAXDATA, lim);
      repeat ($urandom_range(0, 2))
         push_with_bytes($urandom_range(0, 1) ? OP_PEER_LIMIT : OP_QUERY,
                         near_value(peer_hint));
      push_with_bytes(kind ? OP_TAKE_BLOCKED : OP_TAKE_MAXDATA, rand62());
      repeat ($urandom_range(0, 2)) begin
         push_with_bytes(kind ? OP_LOST_BLOCKED : OP_LOST_MAXDATA, lim);
         push_with_bytes(kind ? OP_TAKE_BLOCKED : OP_TAKE_MAXDATA, rand62());
      end
      if ($urandom_range(0, 4) != 0)
         push_with_bytes(kind ? OP_ACK_BLOCKED : OP_ACK_MAXDATA, lim);
   endtask

   // a single event of any kind, spare codes now and then
   task automatic loose_event();
      logic [OP_W-1:0]    op;
      logic [LIMIT_W-1:0] lim;
      if ($urandom_range(0, 24) == 0)
         op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else
         op = OP_W'($urandom_range(OP_QUERY, OP_LOST_BLOCKED));
      case (op)
         OP_PEER_LIMIT:    lim = near_value(peer_hint);
         OP_QUEUE_MAXDATA: lim = $urandom_range(0, 1) ? raise_value(adv_hint)
                                                       : near_value(adv_hint);
         OP_ACK_MAXDATA, OP_LOST_MAXDATA:
            lim = $urandom_range(0, 2) ? md_value : near_value(md_value);
         OP_QUEUE_BLOCKED, OP_ACK_BLOCKED, OP_LOST_BLOCKED:
            lim = $urandom_range(0, 2) ? bk_value : near_value(peer_hint);
         default:          lim = rand62();
      endcase
      push_with_bytes(op, lim);
   endtask

   // response side: runs of ready with random stalls between
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
         repeat (run) @(negedge clock);
         stall = gap_cycles();
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int phase;
      int goal;
      int spin;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = REG_INIT_PEER_LIMIT;
      csr_wdata   = '0;
      peer_hint   = '0;
      adv_hint    = '0;
      md_value    = '0;
      bk_value    = '0;
      events_sent = 0;
      settings_used = 0;
      calm_sender = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset limits, then both frame life cycles step by step
      push_event(OP_QUERY, '0, 62'd10, 62'd0);
      load_limits(62'd1000, 62'd500);
      push_event(OP_QUERY, '0, 62'd2000, 62'd0);
      push_event(OP_QUERY, '0, 62'd500, 62'd600);
      push_event(OP_QUERY, LIM_MAX, LIM_MAX, LIM_MAX);
      push_event(OP_PEER_LIMIT, 62'd800, 62'd900, 62'd100);
      push_event(OP_PEER_LIMIT, 62'd5000, 62'd4000, 62'd100);
      push_event(OP_QUEUE_MAXDATA, 62'd400, 62'd10, 62'd0);
      push_event(OP_TAKE_MAXDATA, '0, 62'd10, 62'd0);
      push_event(OP_QUEUE_MAXDATA, 62'd900, 62'd10, 62'd0);
      push_event(OP_TAKE_MAXDATA, '0, 62'd10, 62'd0);
      push_event(OP_LOST_MAXDATA, 62'd123, 62'd10, 62'd0);
      push_event(OP_LOST_MAXDATA, 62'd900, 62'd10, 62'd0);
      push_event(OP_TAKE_MAXDATA, '0, 62'd10, 62'd0);
      push_event(OP_ACK_MAXDATA, 62'd900, 62'd10, 62'd0);
      push_event(OP_LOST_MAXDATA, 62'd900, 62'd10, 62'd0);
      push_event(OP_TAKE_MAXDATA, '0, 62'd10, 62'd0);
      push_event(OP_QUEUE_BLOCKED, 62'd5000, 62'd6000, 62'd5000);
      push_event(OP_QUEUE_BLOCKED, 62'd5000, 62'd6000, 62'd5000);
      push_event(OP_TAKE_BLOCKED, '0, 62'd6000, 62'd5000);
      push_event(OP_ACK_BLOCKED, 62'd5000, 62'd6000, 62'd5000);
      push_event(OP_QUEUE_BLOCKED, 62'd5000, 62'd6000, 62'd5000);
      push_event(OP_QUEUE_BLOCKED, 62'd6000, 62'd7000, 62'd5000);
      push_event(OP_LOST_BLOCKED, 62'd6000, 62'd7000, 62'd5000);
      push_event(OP_TAKE_BLOCKED, LIM_MAX, 62'd7000, 62'd5000);
      push_event(OP_SPARE_LAST, LIM_MAX, LIM_MAX, 62'd0);
      push_event(OP_PEER_LIMIT, LIM_MAX, LIM_MAX, 62'd0);

      // random phases, each under its own limit setting
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_limits(LIM_MAX, LIM_MAX);
            1: load_limits('0, '0);
            2: load_limits(rand62(), rand62());
            3: load_limits(LIMIT_W'($urandom_range(0, 5000)),
                           LIMIT_W'($urandom_range(0, 5000)));
            default: load_limits(LIM_MAX, '0);
         endcase
         goal = events_sent + EVENTS_PER_PHASE;
         while (events_sent < goal) begin
            calm_sender = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 9) < 7) frame_episode($urandom_range(0, 1));
            else loose_event();
         end
      end
      req_valid = 1'b0;

      // drain, then allow the pipeline a few more cycles
      for (spin = 0; spin < 20000 && results_waiting != 0; spin++) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("%0d events under %0d limit settings, %0d responses compared",
               events_sent, settings_used, results_checked);
      $display("%0d differences, %0d responses never seen", mismatch_count, results_waiting);
      if (mismatch_count == 0 && results_waiting == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
